// ----- hdl/tcrp_pkg.sv -----
// Package for the timed command recorder/player: field widths, mode and
// command codes, the stored entry type and the command-to-action mapping.
// No dependencies.
package tcrp_pkg;

  localparam int unsigned DefaultDepth = 256;

  localparam int unsigned CodeW    = 4;
  localparam int unsigned TimeW    = 32;
  localparam int unsigned ActW     = 4;
  localparam int unsigned ModeW    = 2;
  localparam int unsigned EntriesW = 9;

  typedef enum logic [ModeW-1:0] {
    MODE_IDLE = 2'd0,
    MODE_REC  = 2'd1,
    MODE_PLAY = 2'd2
  } mode_t;

  localparam logic [CodeW-1:0] CODE_NONE      = 4'd0;
  localparam logic [CodeW-1:0] CODE_FORWARD   = 4'd1;
  localparam logic [CodeW-1:0] CODE_BACKWARD  = 4'd2;
  localparam logic [CodeW-1:0] CODE_STOP      = 4'd3;
  localparam logic [CodeW-1:0] CODE_LEFT      = 4'd4;
  localparam logic [CodeW-1:0] CODE_RIGHT     = 4'd5;
  localparam logic [CodeW-1:0] CODE_AHEAD     = 4'd6;
  localparam logic [CodeW-1:0] CODE_ABORT     = 4'd7;
  localparam logic [CodeW-1:0] CODE_RECORD    = 4'd8;
  localparam logic [CodeW-1:0] CODE_STOPREC   = 4'd9;
  localparam logic [CodeW-1:0] CODE_PLAY      = 4'd10;
  localparam logic [CodeW-1:0] CODE_LIGHTSON  = 4'd11;
  localparam logic [CodeW-1:0] CODE_LIGHTSOFF = 4'd12;

  localparam logic [ActW-1:0] ACT_FORWARD   = 4'd0;
  localparam logic [ActW-1:0] ACT_BACKWARD  = 4'd1;
  localparam logic [ActW-1:0] ACT_STOP      = 4'd2;
  localparam logic [ActW-1:0] ACT_LEFT      = 4'd3;
  localparam logic [ActW-1:0] ACT_AHEAD     = 4'd4;
  localparam logic [ActW-1:0] ACT_RIGHT     = 4'd5;
  localparam logic [ActW-1:0] ACT_LIGHTSON  = 4'd6;
  localparam logic [ActW-1:0] ACT_LIGHTSOFF = 4'd7;
  localparam logic [ActW-1:0] ACT_RESET     = 4'd8;
  localparam logic [ActW-1:0] ACT_NONE      = 4'd15;

  typedef struct packed {
    logic [TimeW-1:0] offset;
    logic [CodeW-1:0] code;
  } entry_t;

  function automatic logic [ActW-1:0] code_to_action(input logic [CodeW-1:0] code);
    logic [ActW-1:0] act;
    case (code)
      CODE_FORWARD:   act = ACT_FORWARD;
      CODE_BACKWARD:  act = ACT_BACKWARD;
      CODE_STOP:      act = ACT_STOP;
      CODE_LEFT:      act = ACT_LEFT;
      CODE_RIGHT:     act = ACT_RIGHT;
      CODE_AHEAD:     act = ACT_AHEAD;
      CODE_LIGHTSON:  act = ACT_LIGHTSON;
      CODE_LIGHTSOFF: act = ACT_LIGHTSOFF;
      default:        act = ACT_NONE;
    endcase
    return act;
  endfunction

endpackage

// ----- hdl/tcrp_if.sv -----
// Valid/ready channel interfaces for the recorder/player input and result words.
// Depends on tcrp_pkg.
interface tcrp_in_if;
  logic                        valid;
  logic                        ready;
  logic                        command;
  logic [tcrp_pkg::CodeW-1:0]  code;
  logic [tcrp_pkg::TimeW-1:0]  now;

  modport source (output valid, output command, output code, output now, input ready);
  modport sink   (input valid, input command, input code, input now, output ready);
endinterface

interface tcrp_out_if;
  logic                          valid;
  logic                          ready;
  logic                          has_action;
  logic [tcrp_pkg::ActW-1:0]     action;
  logic [tcrp_pkg::ModeW-1:0]    mode;
  logic [tcrp_pkg::EntriesW-1:0] entries;

  modport source (output valid, output has_action, output action, output mode,
                  output entries, input ready);
  modport sink   (input valid, input has_action, input action, input mode,
                  input entries, output ready);
endinterface

// ----- hdl/tcrp_store.sv -----
// Entry store: single-port-write, single-read synchronous RAM, registered read.
// Depends on tcrp_pkg (entry_t).
module tcrp_store #(
  parameter  int unsigned DEPTH = tcrp_pkg::DefaultDepth,
  localparam int unsigned AddrW = $clog2(DEPTH)
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [AddrW-1:0]     wr_addr,
  input  tcrp_pkg::entry_t     wr_data,
  input  logic [AddrW-1:0]     rd_addr,
  output tcrp_pkg::entry_t     rd_data
);

  tcrp_pkg::entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- hdl/timed_command_recorder_player.sv -----
// Timed command recorder/player. Accepts one word per cycle and returns one
// result word per input word through an output register; the input stalls only
// while that register is full and not being taken. The replay entry is read
// from the entry store ahead of use at the next replay index, so it is ready
// when the next word is handled. No clearing pass is needed after reset.
// Depends on tcrp_pkg, tcrp_if and tcrp_store.
module timed_command_recorder_player #(
  parameter int unsigned DEPTH = tcrp_pkg::DefaultDepth
) (
  input  logic           clk,
  input  logic           rst_n,
  tcrp_in_if.sink        in_ch,
  tcrp_out_if.source     out_ch
);

  localparam int unsigned AddrW = $clog2(DEPTH);
  localparam int unsigned CntW  = $clog2(DEPTH + 1);

  tcrp_pkg::mode_t                 mode_r, mode_nxt;
  logic [tcrp_pkg::TimeW-1:0]      start_r, start_nxt;
  logic [CntW-1:0]                 count_r, count_nxt;
  logic [CntW-1:0]                 idx_r, idx_nxt;

  logic                            out_valid_r;
  logic                            has_action_r;
  logic [tcrp_pkg::ActW-1:0]       action_r;
  logic [tcrp_pkg::ModeW-1:0]      mode_out_r;
  logic [tcrp_pkg::EntriesW-1:0]   entries_r;

  logic                            accept;
  logic [tcrp_pkg::ActW-1:0]       act;
  logic [tcrp_pkg::TimeW-1:0]      elapsed;
  logic                            due;
  logic                            wr_en;
  tcrp_pkg::entry_t                wr_data;
  tcrp_pkg::entry_t                rd_data;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign elapsed     = in_ch.now - start_r;
  assign due         = elapsed >= rd_data.offset;
  assign wr_data     = '{offset: elapsed, code: in_ch.code};

  always_comb begin
    mode_nxt  = mode_r;
    start_nxt = start_r;
    count_nxt = count_r;
    idx_nxt   = idx_r;
    act       = tcrp_pkg::ACT_NONE;
    wr_en     = 1'b0;
    if (accept) begin
      case (mode_r)
        tcrp_pkg::MODE_PLAY: begin
          if (in_ch.command && in_ch.code == tcrp_pkg::CODE_ABORT) begin
            act      = tcrp_pkg::ACT_RESET;
            mode_nxt = tcrp_pkg::MODE_IDLE;
          end else if (idx_r < count_r) begin
            if (due) begin
              act     = tcrp_pkg::code_to_action(rd_data.code);
              idx_nxt = idx_r + 1'b1;
            end
            if (idx_nxt >= count_r) begin
              mode_nxt = tcrp_pkg::MODE_IDLE;
            end
          end else begin
            mode_nxt = tcrp_pkg::MODE_IDLE;
          end
        end
        tcrp_pkg::MODE_REC: begin
          if (in_ch.command) begin
            if (in_ch.code == tcrp_pkg::CODE_STOPREC) begin
              mode_nxt = tcrp_pkg::MODE_IDLE;
            end else begin
              act = tcrp_pkg::code_to_action(in_ch.code);
              if (count_r < CntW'(DEPTH)) begin
                wr_en     = 1'b1;
                count_nxt = count_r + 1'b1;
              end
            end
          end
        end
        default: begin
          mode_nxt = tcrp_pkg::MODE_IDLE;
          if (in_ch.command) begin
            if (in_ch.code == tcrp_pkg::CODE_RECORD) begin
              count_nxt = '0;
              start_nxt = in_ch.now;
              mode_nxt  = tcrp_pkg::MODE_REC;
            end else if (in_ch.code == tcrp_pkg::CODE_PLAY) begin
              start_nxt = in_ch.now;
              idx_nxt   = '0;
              if (count_r != '0) begin
                mode_nxt = tcrp_pkg::MODE_PLAY;
              end
            end else begin
              act = tcrp_pkg::code_to_action(in_ch.code);
            end
          end
        end
      endcase
    end
  end

  // read address tracks the next replay index so the entry is ready in time
  tcrp_store #(
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count_r[AddrW-1:0]),
    .wr_data (wr_data),
    .rd_addr (idx_nxt[AddrW-1:0]),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= tcrp_pkg::MODE_IDLE;
      start_r     <= '0;
      count_r     <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      mode_r  <= mode_nxt;
      start_r <= start_nxt;
      count_r <= count_nxt;
      idx_r   <= idx_nxt;
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      has_action_r <= act != tcrp_pkg::ACT_NONE;
      action_r     <= (act != tcrp_pkg::ACT_NONE) ? act : '0;
      mode_out_r   <= mode_nxt;
      entries_r    <= tcrp_pkg::EntriesW'(count_nxt);
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.has_action = has_action_r;
  assign out_ch.action     = action_r;
  assign out_ch.mode       = mode_out_r;
  assign out_ch.entries    = entries_r;

endmodule

// ----- test/timed_command_recorder_player_tb.sv -----
// Testbench for timed_command_recorder_player: directed and random command words
// with random idling on both channels, checked against a local predictor.
// Depends on tcrp_pkg, tcrp_if and the block itself.
module timed_command_recorder_player_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned StoreDepth = tcrp_pkg::DefaultDepth;
  localparam int WordTarget = 950;
  localparam int WatchdogLimit = 4000;

  typedef struct packed {
    logic                          has_action;
    logic [tcrp_pkg::ActW-1:0]     action;
    logic [tcrp_pkg::ModeW-1:0]    mode;
    logic [tcrp_pkg::EntriesW-1:0] entries;
  } result_t;

  class recorder_checker;
    tcrp_pkg::mode_t            state_mode;
    logic [tcrp_pkg::TimeW-1:0] origin;
    logic [tcrp_pkg::TimeW-1:0] offsets [StoreDepth];
    logic [tcrp_pkg::CodeW-1:0] codes [StoreDepth];
    int               stored;
    int               next_idx;
    result_t          pending[$];
    int               errors;
    int               n_words;
    int               n_results;
    int               n_actions;
    int               n_replays;
    int               n_dropped;
    int               peak_entries;

    function new();
      state_mode = tcrp_pkg::MODE_IDLE;
      origin = '0;
      stored = 0;
      next_idx = 0;
      errors = 0;
      n_words = 0;
      n_results = 0;
      n_actions = 0;
      n_replays = 0;
      n_dropped = 0;
      peak_entries = 0;
    endfunction

    function logic [tcrp_pkg::ActW-1:0] actuator_for(logic [tcrp_pkg::CodeW-1:0] code);
      case (code)
        tcrp_pkg::CODE_FORWARD:   return tcrp_pkg::ACT_FORWARD;
        tcrp_pkg::CODE_BACKWARD:  return tcrp_pkg::ACT_BACKWARD;
        tcrp_pkg::CODE_STOP:      return tcrp_pkg::ACT_STOP;
        tcrp_pkg::CODE_LEFT:      return tcrp_pkg::ACT_LEFT;
        tcrp_pkg::CODE_RIGHT:     return tcrp_pkg::ACT_RIGHT;
        tcrp_pkg::CODE_AHEAD:     return tcrp_pkg::ACT_AHEAD;
        tcrp_pkg::CODE_LIGHTSON:  return tcrp_pkg::ACT_LIGHTSON;
        tcrp_pkg::CODE_LIGHTSOFF: return tcrp_pkg::ACT_LIGHTSOFF;
        default:                  return tcrp_pkg::ACT_NONE;
      endcase
    endfunction

    function void note_word(logic cmd, logic [tcrp_pkg::CodeW-1:0] code,
                            logic [tcrp_pkg::TimeW-1:0] stamp);
      result_t                    r;
      logic [tcrp_pkg::ActW-1:0]  act;
      logic [tcrp_pkg::TimeW-1:0] elapsed;
      act = tcrp_pkg::ACT_NONE;
      n_words++;
      case (state_mode)
        tcrp_pkg::MODE_PLAY: begin
          if (cmd && code == tcrp_pkg::CODE_ABORT) begin
            act = tcrp_pkg::ACT_RESET;
            state_mode = tcrp_pkg::MODE_IDLE;
          end else if (next_idx < stored) begin
            elapsed = stamp - origin;
            if (elapsed >= offsets[next_idx]) begin
              act = actuator_for(codes[next_idx]);
              next_idx++;
            end
            if (next_idx >= stored) state_mode = tcrp_pkg::MODE_IDLE;
          end else begin
            state_mode = tcrp_pkg::MODE_IDLE;
          end
        end
        tcrp_pkg::MODE_REC: begin
          if (cmd) begin
            if (code == tcrp_pkg::CODE_STOPREC) begin
              state_mode = tcrp_pkg::MODE_IDLE;
            end else begin
              act = actuator_for(code);
              if (stored < StoreDepth) begin
                offsets[stored] = stamp - origin;
                codes[stored] = code;
                stored++;
              end else begin
                n_dropped++;
              end
            end
          end
        end
        default: begin
          state_mode = tcrp_pkg::MODE_IDLE;
          if (cmd) begin
            if (code == tcrp_pkg::CODE_RECORD) begin
              stored = 0;
              origin = stamp;
              state_mode = tcrp_pkg::MODE_REC;
            end else if (code == tcrp_pkg::CODE_PLAY) begin
              origin = stamp;
              next_idx = 0;
              if (stored > 0) begin
                state_mode = tcrp_pkg::MODE_PLAY;
                n_replays++;
              end
            end else begin
              act = actuator_for(code);
            end
          end
        end
      endcase
      r.has_action = (act != tcrp_pkg::ACT_NONE);
      r.action = r.has_action ? act : '0;
      r.mode = state_mode;
      r.entries = stored[tcrp_pkg::EntriesW-1:0];
      if (r.has_action) n_actions++;
      if (stored > peak_entries) peak_entries = stored;
      pending.push_back(r);
    endfunction

    function void check_result(result_t got);
      result_t want;
      n_results++;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("%0t: result word with nothing expected: act=%0b/%0d mode=%0d entries=%0d",
                   $realtime, got.has_action, got.action, got.mode, got.entries);
        return;
      end
      want = pending.pop_front();
      if (got.has_action !== want.has_action || got.action !== want.action ||
          got.mode !== want.mode || got.entries !== want.entries) begin
        errors++;
        if (errors <= 10) begin
          $display("%0t: mismatch: expected act=%0b/%0d mode=%0d entries=%0d",
                   $realtime, want.has_action, want.action, want.mode, want.entries);
          $display("    got act=%0b/%0d mode=%0d entries=%0d",
                   got.has_action, got.action, got.mode, got.entries);
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  tcrp_in_if  in_ch();
  tcrp_out_if out_ch();

  timed_command_recorder_player #(.DEPTH(StoreDepth)) uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  recorder_checker            recorder = new();
  logic [tcrp_pkg::TimeW-1:0] tick_now;
  bit               in_calm;
  bit               out_calm;
  int               stall_left;
  int               idle_cycles;

  always #10 clk = ~clk;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [tcrp_pkg::CodeW-1:0] any_code();
    return tcrp_pkg::CodeW'($urandom_range(0, 15));
  endfunction

  // mostly drive/light codes, never stop-record
  function automatic logic [tcrp_pkg::CodeW-1:0] recording_code();
    logic [tcrp_pkg::CodeW-1:0] k;
    do begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5:
          k = tcrp_pkg::CodeW'(tcrp_pkg::CODE_FORWARD + $urandom_range(0, 5));
        6: k = ($urandom_range(0, 1) != 0) ? tcrp_pkg::CODE_LIGHTSON :
                                             tcrp_pkg::CODE_LIGHTSOFF;
        default: k = any_code();
      endcase
    end while (k == tcrp_pkg::CODE_STOPREC);
    return k;
  endfunction

  // called at a falling edge, returns at a falling edge
  task automatic send_word(input logic cmd, input logic [tcrp_pkg::CodeW-1:0] code,
                           input logic [tcrp_pkg::TimeW-1:0] stamp);
    int gap;
    in_ch.valid <= 1'b1;
    in_ch.command <= cmd;
    in_ch.code <= code;
    in_ch.now <= stamp;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
    gap = in_calm ? 0 : pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic issue(input logic cmd, input logic [tcrp_pkg::CodeW-1:0] code,
                       input int max_step);
    tick_now += $urandom_range(0, max_step);
    send_word(cmd, code, tick_now);
  endtask

  // play, then poll until the replay ends; noise and aborts mixed in
  task automatic play_out(input int max_step, input int limit);
    int steps;
    int r;
    steps = 0;
    issue(1'b1, tcrp_pkg::CODE_PLAY, 20);
    while (recorder.state_mode == tcrp_pkg::MODE_PLAY) begin
      r = $urandom_range(0, 99);
      if (steps >= limit || r < 2) issue(1'b1, tcrp_pkg::CODE_ABORT, max_step);
      else if (r < 10) issue(1'b1, any_code(), max_step);
      else issue(1'b0, any_code(), max_step);
      steps++;
    end
  endtask

  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left--;
    end else begin
      out_ch.ready <= 1'b1;
      if (!out_calm && $urandom_range(0, 99) < 25) stall_left = pick_gap();
    end
    if ($urandom_range(0, 199) == 0) out_calm = !out_calm;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready)
        recorder.note_word(in_ch.command, in_ch.code, in_ch.now);
      if (out_ch.valid === 1'b1 && out_ch.ready)
        recorder.check_result({out_ch.has_action, out_ch.action, out_ch.mode,
                               out_ch.entries});
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid === 1'b1 && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("timed_command_recorder_player_tb: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int  n;
    int  pick;
    bit  filled;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.command = 1'b0;
    in_ch.code = tcrp_pkg::CODE_NONE;
    in_ch.now = '0;
    out_ch.ready = 1'b0;
    in_calm = 1'b0;
    out_calm = 1'b0;
    stall_left = 0;
    idle_cycles = 0;
    filled = 1'b0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    // directed: time extremes, empty play, every code in idle
    send_word(1'b0, tcrp_pkg::CODE_NONE, 32'h0000_0000);
    send_word(1'b0, 4'hF, 32'hFFFF_FFFF);
    send_word(1'b1, tcrp_pkg::CODE_PLAY, 32'd5);
    for (int k = 0; k < 16; k++)
      if (k != tcrp_pkg::CODE_RECORD && k != tcrp_pkg::CODE_PLAY)
        send_word(1'b1, k[tcrp_pkg::CodeW-1:0], 32'd10 + k);
    // recording across the time wrap, odd codes stored too
    send_word(1'b1, tcrp_pkg::CODE_RECORD, 32'hFFFF_FFF0);
    send_word(1'b1, tcrp_pkg::CODE_FORWARD, 32'd5);
    send_word(1'b1, tcrp_pkg::CODE_ABORT, 32'd6);
    send_word(1'b0, tcrp_pkg::CODE_STOPREC, 32'd7);
    send_word(1'b1, tcrp_pkg::CODE_PLAY, 32'd8);
    send_word(1'b1, tcrp_pkg::CODE_RECORD, 32'd9);
    send_word(1'b1, 4'hF, 32'd10);
    send_word(1'b1, tcrp_pkg::CODE_LIGHTSON, 32'd40);
    send_word(1'b1, tcrp_pkg::CODE_STOPREC, 32'd41);
    // replay: not yet due, due with a discarded command, silent entry, abort
    send_word(1'b1, tcrp_pkg::CODE_PLAY, 32'd100);
    send_word(1'b0, tcrp_pkg::CODE_NONE, 32'd100);
    send_word(1'b1, tcrp_pkg::CODE_LEFT, 32'd121);
    send_word(1'b0, tcrp_pkg::CODE_NONE, 32'd122);
    send_word(1'b1, tcrp_pkg::CODE_ABORT, 32'd200);
    tick_now = 32'd300;
    play_out(30, 100);

    tick_now = 32'hFFFF_F000;
    while (recorder.n_words < WordTarget) begin
      in_calm = ($urandom_range(0, 4) == 0);
      pick = $urandom_range(0, 99);
      if (!filled && recorder.n_words > 350) begin
        // fill the store past its depth, then replay it
        filled = 1'b1;
        issue(1'b1, tcrp_pkg::CODE_RECORD, 5);
        repeat (StoreDepth + 14) issue(1'b1, recording_code(), 2);
        issue(1'b1, tcrp_pkg::CODE_STOPREC, 2);
        play_out(4, 1000);
      end else if (pick < 40) begin
        issue(1'b1, tcrp_pkg::CODE_RECORD, 20);
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 12);
        repeat (n) begin
          if ($urandom_range(0, 3) == 0) issue(1'b0, any_code(), 30);
          else issue(1'b1, recording_code(), 30);
        end
        if ($urandom_range(0, 6) != 0) issue(1'b1, tcrp_pkg::CODE_STOPREC, 20);
      end else if (pick < 75) begin
        play_out(25, 400);
      end else begin
        repeat ($urandom_range(1, 6)) begin
          if ($urandom_range(0, 9) == 0) tick_now = $urandom;
          issue(1'($urandom_range(0, 1)), any_code(), 1000);
        end
      end
    end

    in_ch.valid <= 1'b0;
    while (recorder.pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("%0d words in, %0d results checked, %0d actions, %0d replays, %0d mismatches",
             recorder.n_words, recorder.n_results, recorder.n_actions, recorder.n_replays,
             recorder.errors);
    $display("store peaked at %0d entries, %0d entries dropped while full",
             recorder.peak_entries, recorder.n_dropped);
    if (recorder.errors == 0 && recorder.pending.size() == 0) begin
      $display("timed_command_recorder_player_tb: PASS");
    end else begin
      $display("timed_command_recorder_player_tb: FAIL");
    end
    $finish;
  end

endmodule
